### sv/bigram_posting_indexer_assert.svh
// Assertion macros used by the bigram posting indexer back end.
`ifndef BIGRAM_POSTING_INDEXER_ASSERT_SVH
`define BIGRAM_POSTING_INDEXER_ASSERT_SVH
`ifndef SYNTHESIS
`define BPI_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpi: same-cycle check failed");
`define BPI_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpi: next-cycle check failed");
`else
`define BPI_ASSERT_IMPL(name, ante, cons)
`define BPI_ASSERT_NEXT(name, ante, cons)
`endif
`endif

### sv/bpi_pkg.sv
// Shared constants, payload types and helpers of the bigram posting indexer.
package bpi_pkg;

    localparam int MAX_WORD_LEN     = 64;
    localparam int WORD_NUMBER_BITS = 24;
    localparam int COUNT_BITS       = 24;
    localparam int ALPHA            = 26;
    localparam int BIGRAMS          = ALPHA * ALPHA;
    localparam int BIGRAM_BITS      = 10;
    localparam int LEN_BITS         = 7;
    localparam int LIST_BITS        = $clog2(MAX_WORD_LEN);
    localparam int CLR_BITS         = $clog2(BIGRAMS);
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_BITS        = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] LOW_A = 8'd97;
    localparam logic [7:0] LOW_Z = 8'd122;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } item_t;

    typedef struct packed {
        logic [BIGRAM_BITS-1:0]      bigram;
        logic [WORD_NUMBER_BITS-1:0] word_number;
        logic [LEN_BITS-1:0]         word_length;
        logic [COUNT_BITS-1:0]       posting_count;
        logic                        truncated;
        logic                        last;
    } posting_t;

    typedef enum logic {
        CMD_PAIR = 1'b0,
        CMD_END  = 1'b1
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                     op;
        logic [BIGRAM_BITS-1:0]      bigram;
        logic [WORD_NUMBER_BITS-1:0] word_number;
        logic [LEN_BITS-1:0]         word_length;
        logic                        truncated;
    } cmd_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= LOW_A) && (c <= LOW_Z);
    endfunction

endpackage

### sv/bigram_posting_indexer.sv
// Top level of the bigram posting indexer: front end, command queue, back end.
//
// Input channel (item_valid / item_stall / item): one transfer per character
// (kind 0) or end-of-word mark (kind 1). Characters are taken one per cycle
// while the command queue has room; each lowercase pair passes the back end
// through a seen-map read, then a list/seen write, so once the queue fills a
// run of pairs is taken only as fast as the back end retires them.
// Output channel (post_valid / post_stall / post): one transfer per posting.
// An end mark walks the unique bigram list; each posting goes through a list
// read, a count read and a count update into the output register, so a word
// with N unique bigrams drains as N postings after its end mark reaches the
// back end.
// Reset: a clearing pass over all 676 entries zeroes the count table and seen
// map; item_stall stays high throughout it.
// Receiver stall: the output register holds the posting; the walk waits,
// the queue fills and then item_stall rises.
module bigram_posting_indexer
    import bpi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_stall,
    input  item_t    item,
    output logic     post_valid,
    input  logic     post_stall,
    output posting_t post
);

    back_status_t status;
    logic         q_full;
    logic         q_empty;
    logic         q_push;
    logic         q_pop;
    cmd_t         q_cmd;
    cmd_t         q_head;

    // classify each transfer into pair and end-of-word commands
    bpi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .status     (status),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    // decouple the character rate from the back end's memory walk
    bpi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    // dedupe bigrams, bump counts, emit postings
    bpi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .status     (status),
        .post_valid (post_valid),
        .post_stall (post_stall),
        .post       (post)
    );

endmodule

### sv/bpi_front.sv
// Front end: take characters, track the word, classify into pair and end commands.
module bpi_front
    import bpi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  item_t        item,
    input  back_status_t status,
    input  logic         q_full,
    output logic         q_push,
    output cmd_t         q_cmd
);

    logic [7:0]                  prev_char_reg,    prev_char_next;
    logic [LEN_BITS-1:0]         char_count_reg,   char_count_next;
    logic                        overflow_reg,     overflow_next;
    logic [WORD_NUMBER_BITS-1:0] word_counter_reg, word_counter_next;

    logic                   accept;
    logic                   full;
    logic                   pair_ok;
    logic [4:0]             p5;
    logic [4:0]             c5;
    logic [BIGRAM_BITS-1:0] pf;
    logic [BIGRAM_BITS-1:0] idx;

    assign item_stall = status.clearing || q_full;
    assign accept     = item_valid && !item_stall;
    assign full       = char_count_reg >= LEN_BITS'(MAX_WORD_LEN);
    assign pair_ok    = (char_count_reg != '0) && is_lower(prev_char_reg) && is_lower(item.ch);

    // first * 26 + second, with 26 = 16 + 8 + 2
    assign p5    = 5'(prev_char_reg - LOW_A);
    assign c5    = 5'(item.ch - LOW_A);
    assign pf    = BIGRAM_BITS'(p5);
    assign idx   = (pf << 4) + (pf << 3) + (pf << 1) + BIGRAM_BITS'(c5);

    always_comb
    begin
        q_push             = 1'b0;
        q_cmd.op           = item.kind ? CMD_END : CMD_PAIR;
        q_cmd.bigram       = idx;
        q_cmd.word_number  = word_counter_reg;
        q_cmd.word_length  = char_count_reg;
        q_cmd.truncated    = overflow_reg;
        prev_char_next     = prev_char_reg;
        char_count_next    = char_count_reg;
        overflow_next      = overflow_reg;
        word_counter_next  = word_counter_reg;
        if (accept)
        begin
            if (!item.kind)
            begin
                if (full)
                begin
                    overflow_next = 1'b1;
                end
                else
                begin
                    q_push          = pair_ok;
                    prev_char_next  = item.ch;
                    char_count_next = char_count_reg + LEN_BITS'(1);
                end
            end
            else
            begin
                q_push = char_count_reg >= LEN_BITS'(2);
                if (char_count_reg != '0)
                begin
                    word_counter_next = word_counter_reg + WORD_NUMBER_BITS'(1);
                end
                prev_char_next  = '0;
                char_count_next = '0;
                overflow_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_char_reg    <= '0;
            char_count_reg   <= '0;
            overflow_reg     <= 1'b0;
            word_counter_reg <= '0;
        end
        else
        begin
            prev_char_reg    <= prev_char_next;
            char_count_reg   <= char_count_next;
            overflow_reg     <= overflow_next;
            word_counter_reg <= word_counter_next;
        end
    end

endmodule

### sv/bpi_queue.sv
// Short command queue between the front end and the back end.
module bpi_queue
    import bpi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    cmd_t                 slots_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wptr_reg, wptr_next;
    logic [QPTR_BITS-1:0] rptr_reg, rptr_next;
    logic [QPTR_BITS:0]   fill_reg, fill_next;
    logic                 do_push;
    logic                 do_pop;

    assign empty   = fill_reg == '0;
    assign full    = fill_reg == (QPTR_BITS + 1)'(QUEUE_DEPTH);
    assign head    = slots_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wptr_next = do_push ? wptr_reg + QPTR_BITS'(1) : wptr_reg;
        rptr_next = do_pop  ? rptr_reg + QPTR_BITS'(1) : rptr_reg;
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + (QPTR_BITS + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - (QPTR_BITS + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

### sv/bpi_back.sv
// Back end: seen map, unique list, count table, posting walk and output register.
`include "bigram_posting_indexer_assert.svh"
module bpi_back
    import bpi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_empty,
    input  cmd_t         q_head,
    output logic         q_pop,
    output back_status_t status,
    output logic         post_valid,
    input  logic         post_stall,
    output posting_t     post
);

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_PAIR,
        B_LREAD,
        B_CREAD,
        B_EMIT
    } state_t;

    state_t                      state_reg;
    logic [CLR_BITS-1:0]         clr_ptr_reg;
    logic [LIST_BITS-1:0]        uc_reg;
    logic [LIST_BITS-1:0]        walk_reg;
    logic [BIGRAM_BITS-1:0]      pair_reg;
    logic [WORD_NUMBER_BITS-1:0] wn_reg;
    logic [LEN_BITS-1:0]         len_reg;
    logic                        trunc_reg;
    logic                        post_valid_reg;
    posting_t                    post_reg;

    logic                   seen_mem  [BIGRAMS];
    logic [COUNT_BITS-1:0]  count_mem [BIGRAMS];
    logic [BIGRAM_BITS-1:0] list_mem  [MAX_WORD_LEN-1];
    logic                   seen_q;
    logic [COUNT_BITS-1:0]  cnt_q;
    logic [BIGRAM_BITS-1:0] list_q;

    logic                   out_free;
    logic                   load_post;
    logic                   is_last;
    logic                   seen_we;
    logic                   seen_wdata;
    logic [BIGRAM_BITS-1:0] seen_waddr;
    logic                   seen_re;
    logic                   count_we;
    logic [BIGRAM_BITS-1:0] count_waddr;
    logic [COUNT_BITS-1:0]  count_wdata;
    logic [COUNT_BITS-1:0]  cnt_next;
    logic                   list_we;

    assign q_pop           = (state_reg == B_IDLE) && !q_empty;
    assign status.clearing = state_reg == B_CLEAR;
    assign out_free        = !post_valid_reg || !post_stall;
    assign load_post       = (state_reg == B_EMIT) && out_free;
    assign is_last         = (walk_reg + LIST_BITS'(1)) == uc_reg;
    assign cnt_next        = (cnt_q == '1) ? cnt_q : cnt_q + COUNT_BITS'(1);
    assign seen_re         = q_pop && (q_head.op == CMD_PAIR);
    assign list_we         = (state_reg == B_PAIR) && !seen_q;
    assign post_valid      = post_valid_reg;
    assign post            = post_reg;

    always_comb
    begin
        seen_we     = 1'b0;
        seen_wdata  = 1'b0;
        seen_waddr  = pair_reg;
        count_we    = 1'b0;
        count_waddr = list_q;
        count_wdata = cnt_next;
        case (state_reg)
            B_CLEAR:
            begin
                seen_we     = 1'b1;
                seen_waddr  = BIGRAM_BITS'(clr_ptr_reg);
                count_we    = 1'b1;
                count_waddr = BIGRAM_BITS'(clr_ptr_reg);
                count_wdata = '0;
            end
            B_PAIR:
            begin
                seen_we    = !seen_q;
                seen_wdata = 1'b1;
            end
            B_CREAD:
            begin
                // drop the seen mark as the walk passes the entry
                seen_we    = 1'b1;
                seen_waddr = list_q;
            end
            B_EMIT:
            begin
                count_we = out_free;
            end
            default:
            begin
                seen_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_waddr] <= seen_wdata;
        end
        if (seen_re)
        begin
            seen_q <= seen_mem[q_head.bigram];
        end
    end

    always_ff @(posedge clk)
    begin
        if (count_we)
        begin
            count_mem[count_waddr] <= count_wdata;
        end
        if (state_reg == B_CREAD)
        begin
            cnt_q <= count_mem[list_q];
        end
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
        begin
            list_mem[uc_reg] <= pair_reg;
        end
        if (state_reg == B_LREAD)
        begin
            list_q <= list_mem[walk_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_CLEAR;
            clr_ptr_reg    <= '0;
            uc_reg         <= '0;
            walk_reg       <= '0;
            pair_reg       <= '0;
            wn_reg         <= '0;
            len_reg        <= '0;
            trunc_reg      <= 1'b0;
            post_valid_reg <= 1'b0;
            post_reg       <= '0;
        end
        else
        begin
            if (load_post)
            begin
                post_valid_reg <= 1'b1;
            end
            else if (!post_stall)
            begin
                post_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_CLEAR:
                begin
                    clr_ptr_reg <= clr_ptr_reg + CLR_BITS'(1);
                    if (clr_ptr_reg == CLR_BITS'(BIGRAMS - 1))
                    begin
                        state_reg <= B_IDLE;
                    end
                end
                B_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (q_head.op == CMD_PAIR)
                        begin
                            pair_reg  <= q_head.bigram;
                            state_reg <= B_PAIR;
                        end
                        else
                        begin
                            wn_reg    <= q_head.word_number;
                            len_reg   <= q_head.word_length;
                            trunc_reg <= q_head.truncated;
                            walk_reg  <= '0;
                            if (uc_reg != '0)
                            begin
                                state_reg <= B_LREAD;
                            end
                        end
                    end
                end
                B_PAIR:
                begin
                    if (!seen_q)
                    begin
                        uc_reg <= uc_reg + LIST_BITS'(1);
                    end
                    state_reg <= B_IDLE;
                end
                B_LREAD:
                begin
                    state_reg <= B_CREAD;
                end
                B_CREAD:
                begin
                    state_reg <= B_EMIT;
                end
                B_EMIT:
                begin
                    if (out_free)
                    begin
                        post_reg.bigram        <= list_q;
                        post_reg.word_number   <= wn_reg;
                        post_reg.word_length   <= len_reg;
                        post_reg.posting_count <= cnt_next;
                        post_reg.truncated     <= trunc_reg;
                        post_reg.last          <= is_last;
                        if (is_last)
                        begin
                            uc_reg    <= '0;
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            walk_reg  <= walk_reg + LIST_BITS'(1);
                            state_reg <= B_LREAD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    `BPI_ASSERT_IMPL(a_no_post_in_clear, state_reg == B_CLEAR, !post_valid_reg)
    `BPI_ASSERT_IMPL(a_no_pop_in_clear, state_reg == B_CLEAR, !q_pop)
    `BPI_ASSERT_NEXT(a_emit_loads_out, (state_reg == B_EMIT) && out_free, post_valid_reg)

endmodule

### test/posting_checker.sv
// Posting predictor and comparator for the bigram posting indexer.
`timescale 1ns / 100ps
module posting_checker
    import bpi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  logic     item_stall,
    input  item_t    item,
    input  logic     post_valid,
    input  logic     post_stall,
    input  posting_t post,
    output int       failures,
    output int       pending
);

    logic [7:0]                  last_ch;
    int                          kept;
    logic                        overlong;
    logic [WORD_NUMBER_BITS-1:0] word_no;
    logic                        in_word [BIGRAMS];
    int                          order [$];
    logic [COUNT_BITS-1:0]       tally [BIGRAMS];
    posting_t                    expected_posts [$];

    assign pending = expected_posts.size();

    task automatic absorb(input item_t it);
        int       idx;
        posting_t p;
        if (it.kind == CMD_PAIR) begin
            if (kept >= MAX_WORD_LEN) begin
                overlong = 1'b1;
                return;
            end
            if (kept >= 1 && last_ch >= LOW_A && last_ch <= LOW_Z
                && it.ch >= LOW_A && it.ch <= LOW_Z) begin
                idx = (last_ch - LOW_A) * ALPHA + (it.ch - LOW_A);
                if (!in_word[idx]) begin
                    in_word[idx] = 1'b1;
                    order.push_back(idx);
                end
            end
            last_ch = it.ch;
            kept++;
            return;
        end
        if (kept >= 2) begin
            foreach (order[i]) begin
                if (tally[order[i]] != {COUNT_BITS{1'b1}})
                    tally[order[i]]++;
                p.bigram        = BIGRAM_BITS'(order[i]);
                p.word_number   = word_no;
                p.word_length   = LEN_BITS'(kept);
                p.posting_count = tally[order[i]];
                p.truncated     = overlong;
                p.last          = (i == order.size() - 1);
                expected_posts.push_back(p);
            end
        end
        foreach (order[i]) in_word[order[i]] = 1'b0;
        if (kept > 0) word_no++;
        order.delete();
        last_ch  = '0;
        kept     = 0;
        overlong = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failures <= 0;
            last_ch = '0;
            kept = 0;
            overlong = 1'b0;
            word_no = '0;
            order.delete();
            expected_posts.delete();
            for (int i = 0; i < BIGRAMS; i++)
            begin
                in_word[i] = 1'b0;
                tally[i] = '0;
            end
        end
        else
        begin
            // check the output side first; a posting can never follow its
            // own end mark in the same cycle
            if (post_valid && !post_stall)
            begin
                if (expected_posts.size() == 0)
                begin
                    $display("%0t: unexpected posting %p", $time, post);
                    failures <= failures + 1;
                end
                else
                begin
                    if (post !== expected_posts[0])
                    begin
                        $display("%0t: expected %p actual %p", $time,
                                 expected_posts[0], post);
                        failures <= failures + 1;
                    end
                    void'(expected_posts.pop_front());
                end
            end
            if (item_valid && !item_stall)
                absorb(item);
        end
    end

endmodule

### test/testbench.sv
// Stimulus and verdict for the bigram posting indexer.
`timescale 1ns / 100ps
module testbench;
    import bpi_pkg::*;

    localparam int LIMIT = 20000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     item_valid = 1'b0;
    logic     item_stall;
    item_t    item = '0;
    logic     post_valid;
    logic     post_stall = 1'b0;
    posting_t post;
    int       failures;
    int       pending;
    int       idle_pct = 37;
    logic     hold_off = 1'b0;
    int       quiet = 0;
    item_t    words [$];

    always #5 clk = ~clk;

    bigram_posting_indexer dut (.*);

    posting_checker checker_i (.*);

    // watchdog: count cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (post_valid && !post_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_off)
            post_stall <= 1'b1;
        else
            post_stall <= ($urandom_range(99) < idle_pct);
    end

    // queue a character transfer
    task automatic add_ch(input logic [7:0] c);
        item_t it;
        it.kind = CMD_PAIR;
        it.ch   = c;
        words.push_back(it);
    endtask

    // queue an end-of-word mark with arbitrary ignored byte
    task automatic add_end();
        item_t it;
        it.kind = CMD_END;
        it.ch   = 8'($urandom_range(255));
        words.push_back(it);
    endtask

    task automatic add_word(input string s);
        foreach (s[i]) add_ch(s[i]);
        add_end();
    endtask

    // drive queued items, idling at random; valid stays up across transfers
    task automatic send_all();
        while (words.size() > 0)
        begin
            if ($urandom_range(99) < idle_pct)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                item_valid <= 1'b1;
                item <= words[0];
                @(posedge clk);
                while (item_stall) @(posedge clk);
                void'(words.pop_front());
            end
        end
        item_valid <= 1'b0;
    endtask

    task automatic random_word(input int len, input bit lower_only);
        for (int i = 0; i < len; i++)
        begin
            if (lower_only || $urandom_range(9) < 8)
                add_ch(8'(LOW_A + $urandom_range(25)));
            else
                add_ch(8'($urandom_range(255)));
        end
        add_end();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, repeats, non-lowercase, empty, short
        add_word("ab");
        add_word("abab");
        add_word("zz");
        add_word("az");
        add_end();
        add_word("q");
        add_word("A1");
        add_word("a-b");
        add_ch(8'hff); add_ch(8'h00); add_ch(8'h80); add_ch(8'h7f); add_end();
        send_all();

        // overlong word, sent as a stretch with no idling on either side
        idle_pct = 0;
        for (int i = 0; i < MAX_WORD_LEN + 1; i++) add_ch(8'(LOW_A + (i % 26)));
        add_end();
        send_all();
        idle_pct = 37;

        // long hold-off on the receiver while the sender keeps offering
        hold_off = 1'b1;
        for (int w = 0; w < 3; w++) random_word(3, 1'b1);
        fork
            send_all();
            begin
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
        join

        // random words, mostly lowercase with some noise
        for (int w = 0; w < 2; w++)
            random_word($urandom_range(1, 6), 1'($urandom_range(1)));
        send_all();

        while (pending > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/bpi_pkg.sv
sv/bpi_front.sv
sv/bpi_queue.sv
sv/bpi_back.sv
sv/bigram_posting_indexer.sv
test/posting_checker.sv
test/testbench.sv
